[hw/rtl/fsmf_pkg.sv]
// shared types and constants for the first substring match finder
`timescale 1ns / 1ps

package fsmf_pkg;

  // default sizes
  localparam int MAX_NEEDLE_DEF    = 64;
  localparam int POSITION_BITS_DEF = 32;

  // stream widths
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // item kinds as carried on the input tuser
  typedef enum logic [MODE_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_HAY    = 2'd2,
    OP_END    = 2'd3
  } op_kind_t;

  // one classified item in the queue
  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] data;
  } op_t;

  // result fields, highest bit first
  typedef struct packed {
    logic [OUT_DATA_W-INDEX_W-3:0] pad;
    logic                          overflow;
    logic [INDEX_W-1:0]            match_index;
    logic                          found;
  } result_t;

endpackage

[hw/rtl/fsmf_front.sv]
// front end: takes input transactions, classifies them and queues them
`timescale 1ns / 1ps

module fsmf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fsmf_pkg::MODE_W-1:0]    in_mode,
  input  logic [fsmf_pkg::BYTE_W-1:0]    in_byte,
  output logic                           q_valid,
  input  logic                           q_ready,
  output fsmf_pkg::op_t                  q_op
);

  fsmf_pkg::op_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  fsmf_pkg::op_t op_in;
  logic          push;
  logic          pop;

  // classify the mode into an operation kind
  always_comb begin
    op_in.data = in_byte;
    op_in.kind = fsmf_pkg::op_kind_t'(in_mode);
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_op     = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= op_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("front queue fill level out of range");

endmodule

[hw/rtl/fsmf_back.sv]
// back end: needle shift line, haystack window, parallel compare and result register
`timescale 1ns / 1ps

module fsmf_back #(
  parameter int MAX_NEEDLE    = fsmf_pkg::MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = fsmf_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  fsmf_pkg::op_t                     q_op,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fsmf_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int CntW = $clog2(MAX_NEEDLE + 1);
  localparam int CmpW = (POSITION_BITS > CntW) ? POSITION_BITS : CntW;
  localparam int ExtW = (POSITION_BITS > fsmf_pkg::INDEX_W) ? POSITION_BITS
                                                            : fsmf_pkg::INDEX_W;
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  // needle kept right-aligned: entry 0 is the last needle byte
  logic [fsmf_pkg::BYTE_W-1:0] needle [MAX_NEEDLE];
  // haystack window: entry 0 is the newest byte
  logic [fsmf_pkg::BYTE_W-1:0] window [MAX_NEEDLE];
  logic [fsmf_pkg::BYTE_W-1:0] window_next [MAX_NEEDLE];

  logic [CntW-1:0]          needle_count;
  logic                     truncated;
  logic [POSITION_BITS-1:0] position;
  logic                     match_seen;
  logic [POSITION_BITS-1:0] first_pos;
  logic                     overflow_seen;

  logic                     pop;
  logic                     is_clear;
  logic                     is_append;
  logic                     is_hay;
  logic                     is_end;
  logic                     saturated;
  logic [POSITION_BITS-1:0] pos_next;
  logic [CmpW-1:0]          pos_ext;
  logic [CmpW-1:0]          cnt_ext;
  logic [CmpW-1:0]          start_ext;
  logic [MAX_NEEDLE-1:0]    lane_ok;
  logic                     hit;
  logic                     res_found;
  logic [ExtW-1:0]          index_ext;
  fsmf_pkg::result_t        result;

  // decode the queued operation
  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_hay    = 1'b0;
    is_end    = 1'b0;
    unique case (q_op.kind)
      fsmf_pkg::OP_CLEAR:  is_clear  = 1'b1;
      fsmf_pkg::OP_APPEND: is_append = 1'b1;
      fsmf_pkg::OP_HAY:    is_hay    = 1'b1;
      default:             is_end    = 1'b1;
    endcase
  end

  // only an end of haystack waits for the result register
  assign q_ready = !is_end || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // window after taking the current byte
  always_comb begin
    window_next[0] = q_op.data;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // per-lane compare, lanes past the needle length always agree
  always_comb begin
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      lane_ok[k] = (CntW'(k) >= needle_count) || (needle[k] == window_next[k]);
    end
  end

  assign saturated = (position == PosMax);
  assign pos_next  = position + POSITION_BITS'(1);
  assign pos_ext   = CmpW'(pos_next);
  assign cnt_ext   = CmpW'(needle_count);
  assign start_ext = pos_ext - cnt_ext;
  assign hit       = (needle_count != '0) && (pos_ext >= cnt_ext) && (&lane_ok);

  // result assembly
  assign res_found  = (needle_count == '0) || (match_seen && !truncated);
  assign index_ext  = ((needle_count != '0) && res_found) ? ExtW'(first_pos) : '0;
  always_comb begin
    result.pad         = '0;
    result.overflow    = overflow_seen || truncated;
    result.match_index = index_ext[fsmf_pkg::INDEX_W-1:0];
    result.found       = res_found;
  end

  // needle and window shift lines
  always_ff @(posedge clk) begin
    if (pop && is_append && (needle_count < CntW'(MAX_NEEDLE))) begin
      for (int k = MAX_NEEDLE - 1; k > 0; k--) begin
        needle[k] <= needle[k-1];
      end
      needle[0] <= q_op.data;
    end
    if (pop && is_hay) begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // match position recorded on first hit
  always_ff @(posedge clk) begin
    if (pop && is_hay && !saturated && !match_seen && hit) begin
      first_pos <= POSITION_BITS'(start_ext);
    end
  end

  // needle length and haystack control state
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_count  <= '0;
      truncated     <= 1'b0;
      position      <= '0;
      match_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      if (is_clear) begin
        needle_count <= '0;
        truncated    <= 1'b0;
      end
      if (is_append) begin
        if (needle_count < CntW'(MAX_NEEDLE)) begin
          needle_count <= needle_count + CntW'(1);
        end else begin
          truncated <= 1'b1;
        end
      end
      if (is_hay) begin
        if (saturated) begin
          overflow_seen <= 1'b1;
        end else begin
          position <= pos_next;
          if (!match_seen && hit) begin
            match_seen <= 1'b1;
          end
        end
      end
      if (is_end) begin
        position      <= '0;
        match_seen    <= 1'b0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      out_data <= result;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    needle_count <= CntW'(MAX_NEEDLE))
    else $error("needle length beyond store");

  a_match_has_pos: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (position != '0))
    else $error("match recorded with no haystack bytes");

  a_ovf_at_sat: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (position == PosMax))
    else $error("position overflow flagged below saturation");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (pop && is_end) |=> out_valid)
    else $error("end of haystack produced no result");

endmodule

[hw/rtl/first_substring_match_finder.sv]
// top level of the first substring match finder
// Usage:
//   s_axis carries one item per transaction: tuser[1:0] is the mode
//   (clear needle, append needle byte, haystack byte, end of haystack) and
//   tdata[7:0] the byte. m_axis returns one result per end of haystack:
//   tdata[0] found, tdata[32:1] match_index, tdata[33] overflow.
//   Items flow at one per cycle while no end of haystack waits on a pending
//   result; the rate is set by the combinational parallel compare of the
//   needle shift line against the haystack window (MAX_NEEDLE byte lanes).
//   An accepted end of haystack passes a queue slot, then the result register.
//   A two-entry queue sits between the input side and the compare engine;
//   when m_axis stalls with a result pending, the engine still processes
//   needle and haystack items and only the next end of haystack waits,
//   after which the queue fills and s_axis_tready drops.
//   Reset (rst, synchronous, active high) empties the queue and the result
//   register, clears the needle length and the haystack position. The
//   needle bytes and window contents need no clearing.
`timescale 1ns / 1ps

module first_substring_match_finder #(
  parameter int MAX_NEEDLE    = fsmf_pkg::MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = fsmf_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fsmf_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] byte_value
  input  logic [fsmf_pkg::MODE_W-1:0]       s_axis_tuser,  // [1:0] mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fsmf_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // [0] found, [32:1] match_index,
                                                           // [33] overflow, [39:34] zero
);

  logic          q_valid;
  logic          q_ready;
  fsmf_pkg::op_t q_op;

  // input side and queue
  fsmf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tuser),
    .in_byte  (s_axis_tdata[fsmf_pkg::BYTE_W-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_op     (q_op)
  );

  // compare engine and result register
  fsmf_back #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
